### sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rhpc_pkg.sv
// Types and constants shared by the RGB565 palette classifier.
package rhpc_pkg;

   localparam int unsigned COORD_W     = 10;
   localparam int unsigned PIXEL_W     = 16;
   localparam int unsigned CODE_W      = 4;
   localparam int unsigned CSR_INDEX_W = 4;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_BLACK  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHITE  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_YELLOW = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED    = 4'd3;

   // Reset values of the palette registers.
   localparam logic [CODE_W-1:0] BLACK_RESET  = 4'd0;
   localparam logic [CODE_W-1:0] WHITE_RESET  = 4'd1;
   localparam logic [CODE_W-1:0] YELLOW_RESET = 4'd2;
   localparam logic [CODE_W-1:0] RED_RESET    = 4'd3;

   // Fixed palette codes.
   localparam logic [CODE_W-1:0] CODE_BLUE  = 4'd5;
   localparam logic [CODE_W-1:0] CODE_GREEN = 4'd6;

   // Channel widening to 8 bits: (c * MUL + ADD) >> 6.
   localparam logic [13:0] WIDEN5_MUL = 14'd527;
   localparam logic [13:0] WIDEN5_ADD = 14'd23;
   localparam logic [13:0] WIDEN6_MUL = 14'd259;
   localparam logic [13:0] WIDEN6_ADD = 14'd33;

   // Saturation limit 0.18 as 50*delta < 9*max, value limit 0.4 as max < 102.
   localparam logic [13:0] SAT_DELTA_MUL = 14'd50;
   localparam logic [13:0] SAT_MAX_MUL   = 14'd9;
   localparam logic [7:0]  BLACK_LIMIT   = 8'd102;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_rgb565;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } req_payload_type;

   typedef struct packed {
      logic [CODE_W-1:0]  color_code;
      logic [COORD_W-1:0] out_column;
      logic [COORD_W-1:0] out_row;
   } rsp_payload_type;

   typedef struct packed {
      logic [CODE_W-1:0] black_code;
      logic [CODE_W-1:0] white_code;
      logic [CODE_W-1:0] yellow_code;
      logic [CODE_W-1:0] red_code;
   } palette_codes_type;

endpackage

### sv/rhpc_csr.sv
// Palette code registers written through the configuration port.
module rhpc_csr
   import rhpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CODE_W-1:0]      csr_wdata,
   output palette_codes_type      codes
);

   palette_codes_type codes_ff;
   palette_codes_type codes_in;

   always_comb begin
      codes_in = codes_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BLACK:  codes_in.black_code  = csr_wdata;
            CSR_WHITE:  codes_in.white_code  = csr_wdata;
            CSR_YELLOW: codes_in.yellow_code = csr_wdata;
            CSR_RED:    codes_in.red_code    = csr_wdata;
            default:    codes_in = codes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.black_code  <= BLACK_RESET;
         codes_ff.white_code  <= WHITE_RESET;
         codes_ff.yellow_code <= YELLOW_RESET;
         codes_ff.red_code    <= RED_RESET;
      end else begin
         codes_ff <= codes_in;
      end
   end

   assign codes = codes_ff;

endmodule

### sv/rhpc_wrap.sv
// Coordinate wrap modulo a constant by a short chain of compare-subtract steps.
module rhpc_wrap
   import rhpc_pkg::*;
#(
   parameter int unsigned MODULUS = 1024
)
(
   input  logic [COORD_W-1:0] coord_in,
   output logic [COORD_W-1:0] coord_out
);

   localparam int unsigned QUOT   = (1 << COORD_W) / MODULUS;
   localparam int unsigned STEPS  = (QUOT < 1) ? 1 : $clog2(QUOT + 1);
   localparam int unsigned WIDE_W = $clog2(MODULUS + 1) + STEPS;

   logic [COORD_W-1:0] rem [0:STEPS];

   assign rem[STEPS] = coord_in;

   // Restoring division: each step removes the modulus shifted by one quotient bit.
   for (genvar k = STEPS - 1; k >= 0; k--) begin : g_step
      localparam logic [WIDE_W-1:0] DIVISOR = WIDE_W'(MODULUS) << k;
      logic [WIDE_W-1:0] rem_wide;
      assign rem_wide = WIDE_W'(rem[k+1]);
      assign rem[k] = (rem_wide >= DIVISOR) ? COORD_W'(rem_wide - DIVISOR) : rem[k+1];
   end

   assign coord_out = rem[0];

endmodule

### sv/rhpc_color.sv
// RGB565 to palette code: channel widening, HSV saturation test and hue bands.
module rhpc_color
   import rhpc_pkg::*;
(
   input  logic [PIXEL_W-1:0] pixel_rgb565,
   input  palette_codes_type  codes,
   output logic [CODE_W-1:0]  color_code
);

   logic [13:0]        r_wide;
   logic [13:0]        g_wide;
   logic [13:0]        b_wide;
   logic [7:0]         r8;
   logic [7:0]         g8;
   logic [7:0]         b8;
   logic [7:0]         mx_rg;
   logic [7:0]         mx;
   logic [7:0]         mn_rg;
   logic [7:0]         mn;
   logic [7:0]         delta;
   logic               is_gray;
   logic signed [13:0] d_s;
   logic signed [13:0] r_s;
   logic signed [13:0] g_s;
   logic signed [13:0] b_s;
   logic signed [13:0] t_red;
   logic signed [13:0] t_green;
   logic signed [13:0] t_blue;

   assign r_wide = 14'(pixel_rgb565[15:11]) * WIDEN5_MUL + WIDEN5_ADD;
   assign g_wide = 14'(pixel_rgb565[10:5])  * WIDEN6_MUL + WIDEN6_ADD;
   assign b_wide = 14'(pixel_rgb565[4:0])   * WIDEN5_MUL + WIDEN5_ADD;
   assign r8 = r_wide[13:6];
   assign g8 = g_wide[13:6];
   assign b8 = b_wide[13:6];

   assign mx_rg = (g8 > r8) ? g8 : r8;
   assign mx    = (b8 > mx_rg) ? b8 : mx_rg;
   assign mn_rg = (g8 < r8) ? g8 : r8;
   assign mn    = (b8 < mn_rg) ? b8 : mn_rg;
   assign delta = mx - mn;

   assign is_gray = (mx == 8'd0) ||
                    ((14'(delta) * SAT_DELTA_MUL) < (14'(mx) * SAT_MAX_MUL));

   assign d_s = $signed({6'b0, delta});
   assign r_s = $signed({6'b0, r8});
   assign g_s = $signed({6'b0, g8});
   assign b_s = $signed({6'b0, b8});
   assign t_red   = g_s - b_s;
   assign t_green = b_s - r_s;
   assign t_blue  = r_s - g_s;

   // Hue bands are compared against delta so that no division is needed.
   always_comb begin
      if (is_gray) begin
         color_code = (mx < BLACK_LIMIT) ? codes.black_code : codes.white_code;
      end else if (mx == r8) begin
         // Red is largest: yellow from 45 degrees up, red otherwise.
         color_code = ((t_red * 14'sd4) >= (d_s * 14'sd3)) ? codes.yellow_code
                                                            : codes.red_code;
      end else if (mx == g8) begin
         if ((t_green * 14'sd2) < -d_s) begin
            color_code = codes.yellow_code;
         end else if ((t_green * 14'sd2) < d_s) begin
            color_code = CODE_GREEN;
         end else begin
            color_code = codes.red_code;
         end
      end else begin
         if (((t_blue * 14'sd3) >= -(d_s * 14'sd2)) && ((t_blue * 14'sd12) < d_s)) begin
            color_code = CODE_BLUE;
         end else begin
            color_code = codes.red_code;
         end
      end
   end

endmodule

### sv/rgb565_hsv_palette_classifier.sv
// Top level of the RGB565 palette classifier: input register, classify logic, result register.
// A beat accepted on req passes the input register, then the result register, to reach rsp.
// Throughput: one pixel per clock unless rsp stalls; both registers form a two-entry pipeline.
// The palette registers accept a write in every cycle (csr_ready is always high).
// Reset is synchronous and active high: it empties both pipeline stages and loads the
// palette registers with black 0, white 1, yellow 2 and red 3.
module rgb565_hsv_palette_classifier
   import rhpc_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned MAX_ROWS    = 1024
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CODE_W-1:0]      csr_wdata
);

   palette_codes_type codes;

   logic              in_valid_ff;
   logic              in_valid_in;
   req_payload_type   in_pay_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   rsp_payload_type   out_pay_ff;
   rsp_payload_type   out_pay_in;
   logic              req_beat;
   logic              out_advance;

   // The configuration port never stalls.
   assign csr_ready = 1'b1;

   rhpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .codes     (codes)
   );

   // The result register takes a new beat when it is empty or being drained this cycle.
   // The input register can then always hand its beat on, so it takes a new one too.
   assign out_advance = !out_valid_ff || rsp_ready;
   assign req_ready   = !in_valid_ff || out_advance;
   assign req_beat    = req_valid && req_ready;

   always_comb begin
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (out_advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_valid_in = out_advance ? in_valid_ff : out_valid_ff;
   end

   // Classification and coordinate wrap sit between the two registers.
   rhpc_color u_color (
      .pixel_rgb565 (in_pay_ff.pixel_rgb565),
      .codes        (codes),
      .color_code   (out_pay_in.color_code)
   );

   rhpc_wrap #(
      .MODULUS (MAX_COLUMNS)
   ) u_wrap_column (
      .coord_in  (in_pay_ff.column),
      .coord_out (out_pay_in.out_column)
   );

   rhpc_wrap #(
      .MODULUS (MAX_ROWS)
   ) u_wrap_row (
      .coord_in  (in_pay_ff.row),
      .coord_out (out_pay_in.out_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load only when a beat moves into them.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_pay_ff <= req_payload;
      end
      if (out_advance && in_valid_ff) begin
         out_pay_ff <= out_pay_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_pay_ff;

endmodule

### sv/rhpc_checker.sv
// Port-level assertions for the palette classifier and their binding to the top level.
`include "assert_macros.svh"

module rhpc_checker
   import rhpc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // Both stages are empty after reset; this checks the result stage through rsp_valid.
   `ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "rsp_valid high after reset")

   // A beat taken on req moves from the input register to rsp when the result side can take it.
   `ASSERT_RST(a_latency, clock, reset, $past(req_valid && req_ready && !reset) && (!rsp_valid || rsp_ready) |=> rsp_valid, "accepted beat did not reach rsp")

   // The input side stalls only when a result waits and the output is stalled.
   `ASSERT_RST(a_stall_cause, clock, reset, !req_ready |-> (rsp_valid && !rsp_ready), "req_ready low without backpressure")

   // A stalled result stays offered and unchanged.
   `ASSERT_RST(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)), "stalled rsp beat changed")

endmodule

bind rgb565_hsv_palette_classifier rhpc_checker u_checker (.*);
